>>> design/chbt_pkg.sv
`timescale 1ns / 1ps
package chbt_pkg;

   localparam int MAX_SIZE_DIGITS = 7;
   localparam int CNT_W = $clog2(MAX_SIZE_DIGITS + 2);
   localparam int ACC_W = 4 * MAX_SIZE_DIGITS;
   localparam int LEFT_W = ACC_W + 1;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_SP = 8'h20;
   localparam logic [7:0] CHAR_HT = 8'h09;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_X_LO = 8'h78;
   localparam logic [7:0] CHAR_X_UP = 8'h58;

   localparam logic [1:0] CLS_SIZE = 2'd0;
   localparam logic [1:0] CLS_DATA = 2'd1;
   localparam logic [1:0] CLS_TRAIL = 2'd2;

   localparam logic [1:0] TRL_NONE = 2'd0;
   localparam logic [1:0] TRL_CR = 2'd1;
   localparam logic [1:0] TRL_CRLF = 2'd2;
   localparam logic [1:0] TRL_CRLFCR = 2'd3;

   typedef enum logic [1:0] {
      PH_SIZE  = 2'd0,
      PH_DATA  = 2'd1,
      PH_TRAIL = 2'd2,
      PH_HALT  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_WS    = 3'd0,
      ST_SIGN  = 3'd1,
      ST_ZERO  = 3'd2,
      ST_PFX   = 3'd3,
      ST_DIG   = 3'd4,
      ST_DONE  = 3'd5,
      ST_NODIG = 3'd6
   } scan_step_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       forward;
      logic [1:0] byte_class;
      logic       end_of_message;
      logic       parse_error;
      logic       halted;
   } result_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.value = 4'(b - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SP) || (b >= CHAR_HT && b <= CHAR_CR);
   endfunction

endpackage

>>> design/chbt_in_stage.sv
`timescale 1ns / 1ps
module chbt_in_stage import chbt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       fire,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_stall = valid_ff && !fire;
   assign take = req_valid && !req_stall;

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_data_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte = byte_ff;

endmodule

>>> design/chbt_parser.sv
`timescale 1ns / 1ps
module chbt_parser import chbt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] in_byte,
   output result_type res
);

   phase_type          phase_ff, phase_in;
   scan_step_type      step_ff, step_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               prev_cr_ff, prev_cr_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic [1:0]         trl_ff, trl_in;

   hex_type            hx;
   logic               line_end;
   logic               has_digit;
   logic               bad_line;
   logic               digit_sig;
   logic [CNT_W-1:0]   cnt_inc;
   logic [CNT_W-1:0]   tk_cnt;
   logic [ACC_W-1:0]   tk_acc;
   logic [LEFT_W-1:0]  left_dec;

   assign hx = hex_decode(in_byte);
   assign line_end = prev_cr_ff && (in_byte == CHAR_LF);
   assign has_digit = (step_ff == ST_ZERO) || (step_ff == ST_PFX) ||
                      (step_ff == ST_DIG) || (step_ff == ST_DONE);
   assign bad_line = !has_digit || (cnt_ff > CNT_W'(MAX_SIZE_DIGITS)) ||
                     (neg_ff && (acc_ff != '0));

   // leading zeros do not count as digits
   assign digit_sig = (hx.value != 4'd0) || (acc_ff != '0) || (cnt_ff != '0);
   assign cnt_inc = (cnt_ff <= CNT_W'(MAX_SIZE_DIGITS)) ? cnt_ff + 1'b1 : cnt_ff;
   assign tk_cnt = digit_sig ? cnt_inc : cnt_ff;
   assign tk_acc = (digit_sig && (cnt_inc <= CNT_W'(MAX_SIZE_DIGITS))) ?
                   {acc_ff[ACC_W-5:0], hx.value} : acc_ff;
   assign left_dec = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

   always_comb begin
      phase_in = phase_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      prev_cr_in = prev_cr_ff;
      left_in = left_ff;
      trl_in = trl_ff;
      unique case (phase_ff)
         PH_SIZE: begin
            if (line_end) begin
               priority if (bad_line) begin
                  phase_in = PH_HALT;
               end else if (acc_ff != '0) begin
                  left_in = LEFT_W'(acc_ff) + LEFT_W'(2);
                  phase_in = PH_DATA;
               end else begin
                  trl_in = TRL_CRLF;
                  phase_in = PH_TRAIL;
               end
               step_in = ST_WS;
               acc_in = '0;
               cnt_in = '0;
               neg_in = 1'b0;
               prev_cr_in = 1'b0;
            end else begin
               prev_cr_in = (in_byte == CHAR_CR);
               unique case (step_ff)
                  ST_WS, ST_SIGN: begin
                     priority if (step_ff == ST_WS && is_space(in_byte)) begin
                        step_in = step_ff;
                     end else if (step_ff == ST_WS &&
                                  (in_byte == CHAR_PLUS || in_byte == CHAR_MINUS)) begin
                        neg_in = (in_byte == CHAR_MINUS);
                        step_in = ST_SIGN;
                     end else if (in_byte == CHAR_ZERO) begin
                        step_in = ST_ZERO;
                     end else if (hx.valid) begin
                        acc_in = tk_acc;
                        cnt_in = tk_cnt;
                        step_in = ST_DIG;
                     end else begin
                        step_in = ST_NODIG;
                     end
                  end
                  ST_ZERO: begin
                     priority if (in_byte == CHAR_X_LO || in_byte == CHAR_X_UP) begin
                        step_in = ST_PFX;
                     end else if (hx.valid) begin
                        acc_in = tk_acc;
                        cnt_in = tk_cnt;
                        step_in = ST_DIG;
                     end else begin
                        step_in = ST_DONE;
                     end
                  end
                  ST_PFX, ST_DIG: begin
                     if (hx.valid) begin
                        acc_in = tk_acc;
                        cnt_in = tk_cnt;
                        step_in = ST_DIG;
                     end else begin
                        step_in = ST_DONE;
                     end
                  end
                  default: begin
                     step_in = step_ff;
                  end
               endcase
            end
         end
         PH_DATA: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_SIZE;
               step_in = ST_WS;
               acc_in = '0;
               cnt_in = '0;
               neg_in = 1'b0;
               prev_cr_in = 1'b0;
            end
         end
         PH_TRAIL: begin
            priority if (in_byte == CHAR_CR) begin
               trl_in = (trl_ff == TRL_CRLF) ? TRL_CRLFCR : TRL_CR;
            end else if (in_byte == CHAR_LF) begin
               if (trl_ff == TRL_CRLFCR) begin
                  phase_in = PH_HALT;
                  trl_in = TRL_NONE;
               end else begin
                  trl_in = (trl_ff == TRL_CR) ? TRL_CRLF : TRL_NONE;
               end
            end else begin
               trl_in = TRL_NONE;
            end
         end
         PH_HALT: begin
            phase_in = PH_HALT;
         end
      endcase
   end

   always_comb begin
      res.out_byte = in_byte;
      res.forward = 1'b1;
      res.byte_class = CLS_SIZE;
      res.end_of_message = 1'b0;
      res.parse_error = 1'b0;
      res.halted = 1'b0;
      unique case (phase_ff)
         PH_SIZE: begin
            if (line_end && bad_line) begin
               res.forward = 1'b0;
               res.parse_error = 1'b1;
            end
         end
         PH_DATA: begin
            res.byte_class = CLS_DATA;
         end
         PH_TRAIL: begin
            res.byte_class = CLS_TRAIL;
            res.end_of_message = (in_byte == CHAR_LF) && (trl_ff == TRL_CRLFCR);
         end
         PH_HALT: begin
            res.forward = 1'b0;
            res.halted = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         step_ff <= ST_WS;
         acc_ff <= '0;
         cnt_ff <= '0;
         neg_ff <= 1'b0;
         prev_cr_ff <= 1'b0;
         left_ff <= '0;
         trl_ff <= TRL_NONE;
      end else if (fire) begin
         phase_ff <= phase_in;
         step_ff <= step_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         neg_ff <= neg_in;
         prev_cr_ff <= prev_cr_in;
         left_ff <= left_in;
         trl_ff <= trl_in;
      end
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT)
      else $error("left halted phase without reset");

   a_data_count_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> left_ff != '0)
      else $error("data phase with empty chunk count");

   a_digit_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_SIZE_DIGITS + 1))
      else $error("digit count overran its limit");

   a_eom_halts: assert property (@(posedge clock) disable iff (reset)
      fire && (res.end_of_message || res.parse_error) |=> phase_ff == PH_HALT)
      else $error("end or error beat did not halt");

endmodule

>>> design/chbt_out_stage.sv
`timescale 1ns / 1ps
module chbt_out_stage import chbt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  result_type res,
   output logic       out_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_res
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      priority if (fire) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res = res_ff;

endmodule

>>> design/http_chunked_body_tracker_unit.sv
`timescale 1ns / 1ps
// a beat is held in the input register, then classified and registered in the result register on rsp
// throughput: one byte per cycle while rsp is not stalled, limited by the parse state update
// an input register and a result register decouple req and rsp; stall on rsp backs up to req
// reset (synchronous, active high) empties both registers and restarts at the size line
module http_chunked_body_tracker_unit import chbt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_forward,
   output logic [1:0] rsp_byte_class,
   output logic       rsp_end_of_message,
   output logic       rsp_parse_error,
   output logic       rsp_halted
);

   logic       in_valid;
   logic [7:0] in_byte;
   logic       out_ready;
   logic       fire;
   result_type res;
   result_type rsp_res;

   assign fire = in_valid && out_ready;

   chbt_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .fire          (fire),
      .in_valid      (in_valid),
      .in_byte       (in_byte)
   );

   chbt_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (in_byte),
      .res     (res)
   );

   chbt_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .res       (res),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_out_byte = rsp_res.out_byte;
   assign rsp_forward = rsp_res.forward;
   assign rsp_byte_class = rsp_res.byte_class;
   assign rsp_end_of_message = rsp_res.end_of_message;
   assign rsp_parse_error = rsp_res.parse_error;
   assign rsp_halted = rsp_res.halted;

endmodule
